// ===== src/mlpsb_pkg.sv =====
// Package for the sigmoid perceptron block: Q8.16 helpers, codes, cell control word.
// No dependencies; used by every module in src.
package mlpsb_pkg;

    localparam int MAX_INPUTS_DEF  = 16;
    localparam int MAX_HIDDEN_DEF  = 16;
    localparam int SIG_DEPTH_DEF   = 256;
    localparam int ADDR_W          = 8;
    localparam int Q_W             = 24;
    localparam int H_W             = 17;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_INFER = 2'd1;
    localparam logic [1:0] OP_TRAIN = 2'd2;

    localparam logic [1:0] SET_IN_HID  = 2'd0;
    localparam logic [1:0] SET_HID_OUT = 2'd1;
    localparam logic [1:0] SET_SKIP    = 2'd2;

    localparam logic [2:0] CFG_INPUT_COUNT  = 3'd0;
    localparam logic [2:0] CFG_HIDDEN_COUNT = 3'd1;
    localparam logic [2:0] CFG_SKIP_ENABLE  = 3'd2;
    localparam logic [2:0] CFG_HIDDEN_BIAS  = 3'd3;
    localparam logic [2:0] CFG_OUTPUT_BIAS  = 3'd4;
    localparam logic [2:0] CFG_SIG_SLOPE    = 3'd5;
    localparam logic [2:0] CFG_LEARN_RATE   = 3'd6;

    typedef logic signed [Q_W-1:0] t_q;

    typedef struct packed {
        logic              acc_init;
        logic              mac_en;
        logic              shift_en;
        logic              p_en;
        logic              upd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] ld_addr;
        t_q                x;
        t_q                ld_data;
        t_q                bias;
        t_q                t_in;
    } t_cell_ctl;

    function automatic t_q sat32(input logic signed [31:0] v);
        if (v > 32'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -32'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic t_q sat_add(input t_q a, input t_q b);
        logic signed [24:0] s;
        s = 25'(a) + 25'(b);
        return sat32(32'(s));
    endfunction

    // product shifted right 16 with floor, then saturated
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [47:0] p;
        p = a * b;
        return sat32($signed(p[47:16]));
    endfunction

    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // logistic table entry, evaluated at elaboration
    function automatic logic [H_W-1:0] sig_entry(input int k, input int depth);
        longint xq;
        longint a;
        longint one;
        longint u;
        longint u2;
        longint u3;
        longint e;
        longint d;
        longint s;
        xq  = longint'(udiv(longint'(k) * 1048576, longint'(depth))) - 524288;
        a   = (xq < 0) ? -xq : xq;
        one = longint'(1) << 30;
        u   = a << 6;
        u2  = (u * u) >>> 30;
        u3  = (u2 * u) >>> 30;
        e   = one - u + u2 / 2 - u3 / 6;
        for (int i = 0; i < 8; i++) begin
            e = (e * e) >>> 30;
        end
        d = one + e;
        s = longint'(udiv(longint'((longint'(1) << 46) + d / 2), longint'(d)));
        return H_W'((xq < 0) ? (65536 - s) : s);
    endfunction

endpackage

// ===== src/mlpsb_sigmoid.sv =====
// Two-stage logistic unit: slope multiply, then clamped constant-table lookup.
// Depends on mlpsb_pkg.
module mlpsb_sigmoid import mlpsb_pkg::*; #(
    parameter int SIG_DEPTH = SIG_DEPTH_DEF,
    parameter int TAG_W     = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [TAG_W-1:0]  i_tag,
    input  t_q                i_x,
    input  logic [22:0]       i_slope,
    output logic              o_valid,
    output logic [TAG_W-1:0]  o_tag,
    output logic [H_W-1:0]    o_h
);
    localparam int TW = $clog2(SIG_DEPTH);
    localparam int PW = 26 + TW;

    logic [H_W-1:0]     w_tab [SIG_DEPTH];
    logic               r_v1;
    logic [TAG_W-1:0]   r_tag1;
    t_q                 r_z;
    logic signed [24:0] w_zz;
    logic [PW-1:0]      w_prod;
    logic [PW-1:0]      w_q;
    logic [TW-1:0]      w_idx;

    for (genvar g = 0; g < SIG_DEPTH; g++) begin : g_tab
        assign w_tab[g] = sig_entry(g, SIG_DEPTH);
    end

    assign w_zz   = 25'(r_z) + 25'sd524288;
    assign w_prod = PW'(w_zz[23:0]) * PW'(SIG_DEPTH);
    assign w_q    = w_prod >> 20;

    always_comb begin
        if (w_zz <= 25'sd0) begin
            w_idx = '0;
        end else if (w_q >= PW'(SIG_DEPTH)) begin
            w_idx = TW'(SIG_DEPTH - 1);
        end else begin
            w_idx = w_q[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z    <= qmul({1'b0, i_slope}, i_x);
        r_tag1 <= i_tag;
        o_tag  <= r_tag1;
        o_h    <= w_tab[w_idx];
    end

endmodule

// ===== src/mlpsb_cell.sv =====
// One hidden node: input weight row, accumulator on the shift chain, update pipe.
// Depends on mlpsb_pkg.
module mlpsb_cell import mlpsb_pkg::*; #(
    parameter int MAX_INPUTS = MAX_INPUTS_DEF
) (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_active,
    input  logic      i_ld_we,
    input  logic      i_t_we,
    input  t_q        i_wout,
    input  t_q        i_acc_next,
    output t_q        o_acc
);
    localparam int IX_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    t_q r_row [MAX_INPUTS];
    t_q r_acc;
    t_q r_t;
    t_q r_p;
    t_q r_wq;
    t_q w_w;

    assign w_w   = r_row[i_ctl.rd_addr[IX_W-1:0]];
    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_init) begin
            r_acc <= i_ctl.bias;
        end else if (i_ctl.mac_en) begin
            r_acc <= sat_add(r_acc, qmul(w_w, i_ctl.x));
        end else if (i_ctl.shift_en) begin
            r_acc <= i_acc_next;
        end
        if (i_t_we) begin
            r_t <= i_ctl.t_in;
        end
        if (i_ctl.p_en) begin
            r_p  <= qmul(i_wout, i_ctl.x);
            r_wq <= w_w;
        end
        if (i_ld_we) begin
            r_row[i_ctl.ld_addr[IX_W-1:0]] <= i_ctl.ld_data;
        end else if (i_ctl.upd_en && i_active) begin
            r_row[i_ctl.wr_addr[IX_W-1:0]] <= sat_add(r_wq, qmul(r_t, r_p));
        end
    end

endmodule

// ===== src/mlp_sigmoid_backprop_step.sv =====
// Top level of the sigmoid perceptron with backpropagation: sequencer, central stores.
// Depends on mlpsb_pkg, mlpsb_cell, mlpsb_sigmoid.
//
// Input channel (i_in_valid / o_in_stall): one word per load or sample element.
// Loads and non-final elements are stored and start no pass. The final element of a
// pattern starts a pass through the row of hidden cells: parallel MACs, the sums
// shifted out through the shared sigmoid unit, a skip step (accumulating the skip
// terms when enabled), the output sigmoid, then the emit step. Training adds the
// steps gain, output weights, node gradients, input weights and skip weights.
// Output channel (o_out_valid / i_out_stall): prediction and error held in an
// output register; a stalled word is held and the block waits in its emit step
// only if a second result arrives before the first is taken.
// Input is stalled throughout a pattern's pass.
// Config channel (i_cfg_valid / o_cfg_ready): always ready, write only while idle.
// Reset: synchronous, active low; registers return to their defaults, the weight
// and input stores keep their contents and must be loaded before use.
module mlp_sigmoid_backprop_step import mlpsb_pkg::*; #(
    parameter int MAX_INPUTS = MAX_INPUTS_DEF,
    parameter int MAX_HIDDEN = MAX_HIDDEN_DEF,
    parameter int SIG_DEPTH  = SIG_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_weight_set,
    input  logic [3:0]  i_hidden_index,
    input  logic [3:0]  i_input_index,
    input  logic signed [23:0] i_data_value,
    input  logic signed [23:0] i_target_value,
    input  logic        i_last_element,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [16:0] o_prediction,
    output logic signed [23:0] o_output_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    localparam int IX_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int HX_W  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int MAXN  = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
    localparam int CW0   = $clog2(MAXN + 3);
    localparam int CNT_W = (CW0 > 5) ? CW0 : 5;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MAC  = 4'd1;
    localparam logic [3:0] ST_HID  = 4'd2;
    localparam logic [3:0] ST_SKIP = 4'd3;
    localparam logic [3:0] ST_OSIG = 4'd4;
    localparam logic [3:0] ST_OUT  = 4'd5;
    localparam logic [3:0] ST_GAIN = 4'd6;
    localparam logic [3:0] ST_WO   = 4'd7;
    localparam logic [3:0] ST_TD   = 4'd8;
    localparam logic [3:0] ST_WIH  = 4'd9;
    localparam logic [3:0] ST_SKW  = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [4:0]  r_in_cnt;
    logic [4:0]  r_hid_cnt;
    logic        r_skip;
    t_q          r_hbias;
    t_q          r_obias;
    logic [22:0] r_slope;
    logic [22:0] r_lrate;

    t_q             r_x  [MAX_INPUTS];
    t_q             r_ws [MAX_INPUTS];
    t_q             r_wo [MAX_HIDDEN];
    logic [H_W-1:0] r_h  [MAX_HIDDEN];

    logic           r_train;
    t_q             r_target;
    t_q             r_pred;
    logic [H_W-1:0] r_ph;
    t_q             r_err;
    t_q             r_g;
    t_q             r_p1;
    t_q             r_hq1;
    t_q             r_p2;
    logic           r_pv1;
    logic           r_pv2;
    logic [CNT_W-1:0] r_pi1;
    logic [CNT_W-1:0] r_pi2;

    logic [CNT_W-1:0] w_ni;
    logic [CNT_W-1:0] w_nh;
    logic             w_in_acc;
    logic             w_sample;
    logic             w_ii_ok;
    logic             w_hi_ok;
    logic             w_out_free;
    logic [IX_W-1:0]  w_xaddr;
    logic [HX_W-1:0]  w_haddr;
    t_q               w_x_rd;
    t_q               w_wo_rd;
    t_q               w_h_rd;
    t_q               w_ph_s;
    t_q               w_err;
    t_cell_ctl        w_ctl;
    t_q               w_acc [MAX_HIDDEN+1];

    logic             w_sig_iv;
    logic             w_sig_ov;
    logic [CNT_W-1:0] w_sig_tag;
    logic [H_W-1:0]   w_sig_h;
    t_q               w_sig_x;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_sample    = (i_opcode == OP_INFER) || (i_opcode == OP_TRAIN);
    assign w_ii_ok     = 32'(i_input_index) < MAX_INPUTS;
    assign w_hi_ok     = 32'(i_hidden_index) < MAX_HIDDEN;
    assign w_out_free  = !o_out_valid || !i_out_stall;

    assign w_ni = (CNT_W'(r_in_cnt) > CNT_W'(MAX_INPUTS)) ? CNT_W'(MAX_INPUTS)
                                                           : CNT_W'(r_in_cnt);
    assign w_nh = (CNT_W'(r_hid_cnt) > CNT_W'(MAX_HIDDEN)) ? CNT_W'(MAX_HIDDEN)
                                                            : CNT_W'(r_hid_cnt);

    assign w_xaddr = r_cnt[IX_W-1:0];
    assign w_haddr = (r_state == ST_HID) ? w_sig_tag[HX_W-1:0] : r_cnt[HX_W-1:0];
    assign w_x_rd  = r_x[w_xaddr];
    assign w_wo_rd = r_wo[w_haddr];
    assign w_h_rd  = t_q'({7'b0, r_h[w_haddr]});
    assign w_ph_s  = t_q'({7'b0, r_ph});
    assign w_err   = sat_add(r_target, 24'sd0 - w_ph_s);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_in_acc && w_sample && i_last_element) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_cnt == w_ni) begin
                    n_state = ST_HID;
                    n_cnt   = '0;
                end
            end
            ST_HID: begin
                if (r_cnt == w_nh + CNT_W'(2)) begin
                    n_state = ST_SKIP;
                    n_cnt   = '0;
                end
            end
            ST_SKIP: begin
                if (!r_skip || r_cnt == w_ni) begin
                    n_state = ST_OSIG;
                    n_cnt   = '0;
                end
            end
            ST_OSIG: begin
                if (w_sig_ov) begin
                    n_state = ST_OUT;
                    n_cnt   = '0;
                end
            end
            ST_OUT: begin
                n_cnt = '0;
                if (w_out_free) begin
                    n_state = r_train ? ST_GAIN : ST_IDLE;
                end
            end
            ST_GAIN: begin
                n_state = ST_WO;
                n_cnt   = '0;
            end
            ST_WO: begin
                if (r_cnt == w_nh) begin
                    n_state = ST_TD;
                    n_cnt   = '0;
                end
            end
            ST_TD: begin
                if (r_cnt == w_nh + CNT_W'(2)) begin
                    n_state = ST_WIH;
                    n_cnt   = '0;
                end
            end
            ST_WIH: begin
                if (r_cnt == w_ni + CNT_W'(1)) begin
                    n_state = ST_SKW;
                    n_cnt   = '0;
                end
            end
            ST_SKW: begin
                if (!r_skip || r_cnt == w_ni) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_in_cnt    <= 5'd1;
            r_hid_cnt   <= 5'd1;
            r_skip      <= 1'b0;
            r_hbias     <= '0;
            r_obias     <= '0;
            r_slope     <= 23'd65536;
            r_lrate     <= 23'd6554;
            o_out_valid <= 1'b0;
            r_pv1       <= 1'b0;
            r_pv2       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_INPUT_COUNT:  r_in_cnt  <= i_cfg_data[4:0];
                    CFG_HIDDEN_COUNT: r_hid_cnt <= i_cfg_data[4:0];
                    CFG_SKIP_ENABLE:  r_skip    <= i_cfg_data[0];
                    CFG_HIDDEN_BIAS:  r_hbias   <= i_cfg_data;
                    CFG_OUTPUT_BIAS:  r_obias   <= i_cfg_data;
                    CFG_SIG_SLOPE:    r_slope   <= i_cfg_data[22:0];
                    CFG_LEARN_RATE:   r_lrate   <= i_cfg_data[22:0];
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            r_pv1 <= (r_state == ST_TD && r_cnt < w_nh) || (r_state == ST_WIH && r_cnt < w_ni);
            r_pv2 <= r_pv1 && (r_state == ST_TD);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pi1 <= r_cnt;
        r_pi2 <= r_pi1;
        if (w_in_acc) begin
            if (i_opcode == OP_LOAD) begin
                if (i_weight_set == SET_HID_OUT && w_hi_ok) begin
                    r_wo[HX_W'(i_hidden_index)] <= i_data_value;
                end else if (i_weight_set == SET_SKIP && w_ii_ok) begin
                    r_ws[IX_W'(i_input_index)] <= i_data_value;
                end
            end else if (w_sample) begin
                if (w_ii_ok) begin
                    r_x[IX_W'(i_input_index)] <= i_data_value;
                end
                if (i_last_element) begin
                    r_train  <= (i_opcode == OP_TRAIN);
                    r_target <= i_target_value;
                    r_pred   <= r_obias;
                end
            end
        end
        if (r_state == ST_HID && w_sig_ov) begin
            r_h[w_haddr] <= w_sig_h;
            r_pred       <= sat_add(r_pred, qmul(w_wo_rd, t_q'({7'b0, w_sig_h})));
        end
        if (r_state == ST_SKIP && r_skip && r_cnt != w_ni) begin
            r_pred <= sat_add(r_pred, qmul(r_ws[w_xaddr], w_x_rd));
        end
        if (r_state == ST_OSIG && w_sig_ov) begin
            r_ph <= w_sig_h;
        end
        if (r_state == ST_OUT && w_out_free) begin
            o_prediction   <= r_ph;
            o_output_error <= w_err;
            r_err          <= w_err;
        end
        if (r_state == ST_GAIN) begin
            r_g <= qmul({1'b0, r_lrate}, r_err);
        end
        if (r_state == ST_WO && r_cnt != w_nh) begin
            r_wo[w_haddr] <= sat_add(w_wo_rd, qmul(r_g, w_h_rd));
        end
        if (r_state == ST_TD) begin
            r_p1  <= qmul({1'b0, r_slope}, w_h_rd);
            r_hq1 <= 24'sd65536 - w_h_rd;
            r_p2  <= qmul(r_p1, r_hq1);
        end
        if (r_state == ST_SKW && r_skip && r_cnt != w_ni) begin
            r_ws[w_xaddr] <= sat_add(r_ws[w_xaddr], qmul(r_g, w_x_rd));
        end
    end

    // shared sigmoid: hidden sums from the chain head, then the output sum
    assign w_sig_iv = (r_state == ST_HID && r_cnt < w_nh) || (r_state == ST_OSIG && r_cnt == '0);
    assign w_sig_x  = (r_state == ST_HID) ? w_acc[0] : r_pred;

    mlpsb_sigmoid #(
        .SIG_DEPTH (SIG_DEPTH),
        .TAG_W     (CNT_W)
    ) u_sig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sig_iv),
        .i_tag   (r_cnt),
        .i_x     (w_sig_x),
        .i_slope (r_slope),
        .o_valid (w_sig_ov),
        .o_tag   (w_sig_tag),
        .o_h     (w_sig_h)
    );

    always_comb begin
        w_ctl          = '0;
        w_ctl.acc_init = w_in_acc && w_sample && i_last_element;
        w_ctl.mac_en   = (r_state == ST_MAC) && (r_cnt != w_ni);
        w_ctl.shift_en = (r_state == ST_HID) && (r_cnt < w_nh);
        w_ctl.p_en     = (r_state == ST_WIH) && (r_cnt < w_ni);
        w_ctl.upd_en   = (r_state == ST_WIH) && r_pv1;
        w_ctl.rd_addr  = ADDR_W'(r_cnt);
        w_ctl.wr_addr  = ADDR_W'(r_pi1);
        w_ctl.ld_addr  = ADDR_W'(i_input_index);
        w_ctl.x        = w_x_rd;
        w_ctl.ld_data  = i_data_value;
        w_ctl.bias     = r_hbias;
        w_ctl.t_in     = qmul(r_g, r_p2);
    end

    assign w_acc[MAX_HIDDEN] = '0;

    for (genvar g = 0; g < MAX_HIDDEN; g++) begin : g_cell
        mlpsb_cell #(
            .MAX_INPUTS (MAX_INPUTS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_active   (32'(w_nh) > g),
            .i_ld_we    (w_in_acc && i_opcode == OP_LOAD && i_weight_set == SET_IN_HID
                         && w_ii_ok && 32'(i_hidden_index) == g),
            .i_t_we     (r_state == ST_TD && r_pv2 && 32'(r_pi2) == g),
            .i_wout     (r_wo[g]),
            .i_acc_next (w_acc[g+1]),
            .o_acc      (w_acc[g])
        );
    end

    a_load_no_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_opcode == OP_LOAD) |=> (r_state == ST_IDLE))
        else $error("load started a pass");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_out_free) |=> o_out_valid)
        else $error("result not presented");

    a_pred_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_prediction <= 17'd65536))
        else $error("prediction out of range");

endmodule
